// File: hw/rtl/rgb_sharpen_3x3_clamped_edges_defines.svh
// Assertion macros shared by the sharpening filter RTL.
// Both sample on clk_i; the first is masked while rst_ni is low.
`ifndef RGB_SHARPEN_3X3_CLAMPED_EDGES_DEFINES_SVH
`define RGB_SHARPEN_3X3_CLAMPED_EDGES_DEFINES_SVH

// Check a property outside reset.
`define RSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define RSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/rsh_pkg.sv
`default_nettype none

package rsh_pkg;

  // Configuration port layout
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned IMG_W_REG_W = 11;
  localparam int unsigned IMG_H_REG_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // Three row banks rotate: row y lives in bank y mod 3
  localparam int unsigned NUM_BANKS = 3;
  typedef logic [1:0] bank_t;
  localparam bank_t BANK_0 = 2'd0;
  localparam bank_t BANK_1 = 2'd1;
  localparam bank_t BANK_2 = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // One vertical column of the 3x3 window
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Per-word control carried from the counters into the filter stage
  typedef struct packed {
    logic  emit;
    logic  last;
    logic  first_col;
    logic  last_col;
    logic  top_clamp;
    logic  bot_clamp;
    bank_t mid_bank;
    bank_t top_bank;
  } tag_t;

  // Line buffer strobes
  typedef struct packed {
    logic  wr_en;
    logic  rd_en;
    bank_t wr_bank;
  } mem_ctl_t;

  typedef logic [8:0][7:0] taps_t;

  localparam int unsigned CENTRE_TAP = 4;

  function automatic bank_t bank_next(bank_t b);
    case (b)
      BANK_0:  bank_next = BANK_1;
      BANK_1:  bank_next = BANK_2;
      default: bank_next = BANK_0;
    endcase
  endfunction

  function automatic bank_t bank_prev(bank_t b);
    case (b)
      BANK_1:  bank_prev = BANK_0;
      BANK_2:  bank_prev = BANK_1;
      default: bank_prev = BANK_2;
    endcase
  endfunction

  // Nine at the centre, minus one for each neighbour, clamped to a byte
  function automatic logic [7:0] sharpen_chan(taps_t taps);
    logic signed [12:0] acc;
    acc = $signed({2'b00, taps[CENTRE_TAP], 3'b000}) + $signed({5'b00000, taps[CENTRE_TAP]});
    for (int i = 0; i < 9; i++) begin
      if (i != CENTRE_TAP) begin
        acc = acc - $signed({5'b00000, taps[i]});
      end
    end
    if (acc < 13'sd0) begin
      sharpen_chan = 8'h00;
    end else if (acc > 13'sd255) begin
      sharpen_chan = 8'hFF;
    end else begin
      sharpen_chan = acc[7:0];
    end
  endfunction

  function automatic pix_t sharpen(col_t l, col_t c, col_t r);
    pix_t  px [9];
    taps_t tr;
    taps_t tg;
    taps_t tb;
    pix_t  res;
    px = '{l.top, l.mid, l.bot, c.top, c.mid, c.bot, r.top, r.mid, r.bot};
    for (int i = 0; i < 9; i++) begin
      tr[i] = px[i].red;
      tg[i] = px[i].green;
      tb[i] = px[i].blue;
    end
    res.red   = sharpen_chan(tr);
    res.green = sharpen_chan(tg);
    res.blue  = sharpen_chan(tb);
    sharpen = res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rsh_line_ram.sv
`default_nettype none

module rsh_line_ram #(
  parameter int unsigned  Depth = 1024,
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  rsh_pkg::pix_t wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output rsh_pkg::pix_t rdata_o
);
  import rsh_pkg::*;

  pix_t mem_q [Depth];
  pix_t rdata_q;

  // Write one pixel, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/rsh_ctrl.sv
`default_nettype none

module rsh_ctrl #(
  parameter int unsigned  MaxWidth  = 1024,
  parameter int unsigned  MaxHeight = 4096,
  localparam int unsigned XW = $clog2(MaxWidth + 1),
  localparam int unsigned YW = $clog2(MaxHeight + 1),
  localparam int unsigned AW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [rsh_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rsh_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             ready_i,
  output logic                             take_o,
  output rsh_pkg::tag_t                    tag_o,
  output rsh_pkg::mem_ctl_t                mem_ctl_o,
  output logic [AW-1:0]                    mem_addr_o
);
  import rsh_pkg::*;

  logic [XW-1:0] eff_w_q, eff_w_d, in_x_q, in_x_d, out_x_q, out_x_d, w_last;
  logic [YW-1:0] eff_h_q, eff_h_d, in_y_q, in_y_d, out_y_q, out_y_d, h_last;
  bank_t         bank_q, bank_d;
  logic          take, cfg_we, in_pix, emit, last;
  logic [IMG_W_REG_W-1:0] raw_w;
  logic [IMG_H_REG_W-1:0] raw_h;

  assign take   = in_valid_i && ready_i;
  assign take_o = take;
  assign raw_w  = cfg_data_i[IMG_W_REG_W-1:0];
  assign raw_h  = cfg_data_i[IMG_H_REG_W-1:0];

  // Decode register writes, clamp the frame size to the supported range
  always_comb begin
    eff_w_d = eff_w_q;
    eff_h_d = eff_h_q;
    cfg_we  = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH: begin
          cfg_we = 1'b1;
          if (raw_w == '0) begin
            eff_w_d = XW'(1);
          end else if (32'(raw_w) > 32'(MaxWidth)) begin
            eff_w_d = XW'(MaxWidth);
          end else begin
            eff_w_d = XW'(raw_w);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          cfg_we = 1'b1;
          if (raw_h == '0) begin
            eff_h_d = YW'(1);
          end else if (32'(raw_h) > 32'(MaxHeight)) begin
            eff_h_d = YW'(MaxHeight);
          end else begin
            eff_h_d = YW'(raw_h);
          end
        end
        default: ;
      endcase
    end
  end

  // Position flags for the word at the input
  assign w_last = eff_w_q - XW'(1);
  assign h_last = eff_h_q - YW'(1);
  assign in_pix = (in_y_q != eff_h_q);
  assign emit   = (in_y_q > YW'(1)) || ((in_y_q == YW'(1)) && (in_x_q != '0));
  assign last   = emit && (out_y_q == h_last) && (out_x_q == w_last);

  always_comb begin
    tag_o.emit      = emit;
    tag_o.last      = last;
    tag_o.first_col = (out_x_q == '0);
    tag_o.last_col  = (out_x_q == w_last);
    tag_o.top_clamp = (in_y_q == YW'(1));
    tag_o.bot_clamp = (in_y_q == eff_h_q);
    tag_o.mid_bank  = bank_prev(bank_q);
    tag_o.top_bank  = bank_next(bank_q);
  end

  // Drain words past the last column read a harmless address
  assign mem_addr_o        = (in_x_q < eff_w_q) ? in_x_q[AW-1:0] : '0;
  assign mem_ctl_o.wr_en   = take && in_pix;
  assign mem_ctl_o.rd_en   = take;
  assign mem_ctl_o.wr_bank = bank_q;

  // Advance the input and output raster positions
  always_comb begin
    in_x_d  = in_x_q;
    in_y_d  = in_y_q;
    out_x_d = out_x_q;
    out_y_d = out_y_q;
    bank_d  = bank_q;
    if (cfg_we || (take && last)) begin
      in_x_d  = '0;
      in_y_d  = '0;
      out_x_d = '0;
      out_y_d = '0;
      bank_d  = BANK_0;
    end else if (take) begin
      if (in_pix && (in_x_q == w_last)) begin
        in_x_d = '0;
        in_y_d = in_y_q + YW'(1);
        bank_d = bank_next(bank_q);
      end else begin
        in_x_d = in_x_q + XW'(1);
      end
      if (emit) begin
        if (out_x_q == w_last) begin
          out_x_d = '0;
          out_y_d = out_y_q + YW'(1);
        end else begin
          out_x_d = out_x_q + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= XW'(1);
      eff_h_q <= YW'(1);
      in_x_q  <= '0;
      in_y_q  <= '0;
      out_x_q <= '0;
      out_y_q <= '0;
      bank_q  <= BANK_0;
    end else begin
      eff_w_q <= eff_w_d;
      eff_h_q <= eff_h_d;
      in_x_q  <= in_x_d;
      in_y_q  <= in_y_d;
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      bank_q  <= bank_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rsh_filter.sv
`default_nettype none

module rsh_filter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  rsh_pkg::tag_t tag_i,
  input  rsh_pkg::pix_t pix_i,
  input  rsh_pkg::pix_t bank_rd_i [rsh_pkg::NUM_BANKS],
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rsh_pkg::pix_t out_pix_o,
  output logic          frame_last_o
);
  import rsh_pkg::*;
  `include "rgb_sharpen_3x3_clamped_edges_defines.svh"

  logic s1_valid_q, s1_valid_d, s1_adv;
  tag_t s1_tag_q;
  pix_t s1_pix_q;
  col_t win_l_q, win_c_q, cur_col, left_col, right_col;
  pix_t mid_rd, top_rd, result, out_pix_q;
  logic out_valid_q, out_valid_d, frame_last_q;

  function automatic pix_t bank_sel(bank_t b, pix_t rd [NUM_BANKS]);
    case (b)
      BANK_1:  bank_sel = rd[1];
      BANK_2:  bank_sel = rd[2];
      default: bank_sel = rd[0];
    endcase
  endfunction

  // Stage moves on unless its result finds the output word still occupied
  assign s1_adv  = s1_valid_q && (!s1_tag_q.emit || !out_valid_q || out_ready_i);
  assign ready_o = !s1_valid_q || s1_adv;

  // Build the newest column, replicating the top and bottom rows at the edges
  assign mid_rd = bank_sel(s1_tag_q.mid_bank, bank_rd_i);
  assign top_rd = bank_sel(s1_tag_q.top_bank, bank_rd_i);
  always_comb begin
    cur_col.mid = mid_rd;
    cur_col.top = s1_tag_q.top_clamp ? mid_rd : top_rd;
    cur_col.bot = s1_tag_q.bot_clamp ? mid_rd : s1_pix_q;
  end

  // Replicate the side columns at the row ends
  assign left_col  = s1_tag_q.first_col ? win_c_q : win_l_q;
  assign right_col = s1_tag_q.last_col ? win_c_q : cur_col;
  assign result    = sharpen(left_col, win_c_q, right_col);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && s1_tag_q.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input word, shift the window, load the output word
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_tag_q <= tag_i;
      s1_pix_q <= pix_i;
    end
    if (s1_adv) begin
      win_l_q <= win_c_q;
      win_c_q <= cur_col;
      if (s1_tag_q.emit) begin
        out_pix_q    <= result;
        frame_last_q <= s1_tag_q.last;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pix_o    = out_pix_q;
  assign frame_last_o = frame_last_q;

  `RSH_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_q && !s1_valid_q, "pipeline not empty in reset")
  `RSH_ASSERT(a_no_overrun, take_i |-> !s1_valid_q || s1_adv, "word taken over a held stage")
  `RSH_ASSERT(a_emit_lands, s1_adv && s1_tag_q.emit |=> out_valid_q && (frame_last_q == $past(s1_tag_q.last)), "result lost on way to output")
  `RSH_ASSERT(a_last_corner, s1_valid_q && s1_tag_q.last |-> s1_tag_q.emit && s1_tag_q.last_col && s1_tag_q.bot_clamp, "frame end off the bottom right corner")

endmodule

`default_nettype wire

// File: hw/rtl/rgb_sharpen_3x3_clamped_edges.sv
// Channel  Handshake                   Payload
// cfg      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i (0 width, 1 height)
// in       in_valid_i / in_ready_o     kind_i, pixel_red_i, pixel_green_i, pixel_blue_i
// out      out_valid_o / out_ready_i   out_red_o, out_green_o, out_blue_o, frame_last_o
//
// One word per cycle in and out while the output is not held; the word that completes
// a window passes the line buffer read register, then the output register, on its way out.
// The three row banks are single write, single read RAMs; each pixel word writes one and
// every word reads all three, so a word can enter on every cycle the stage is not held.
// Reset clears counters and valids; frame size returns to 1x1. Line buffers are not cleared.
// A held output word stalls the stage only while it holds a word that carries a result; others still pass.
`default_nettype none

module rgb_sharpen_3x3_clamped_edges #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rsh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rsh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [7:0]                     pixel_red_i,
  input  logic [7:0]                     pixel_green_i,
  input  logic [7:0]                     pixel_blue_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_red_o,
  output logic [7:0]                     out_green_o,
  output logic [7:0]                     out_blue_o,
  output logic                           frame_last_o
);
  import rsh_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic          take, ready, kind_unused;
  tag_t          tag;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_addr;
  pix_t          in_pix, out_pix;
  pix_t          bank_rd [NUM_BANKS];

  // Position in the frame decides pixel or drain; the kind bit is not needed
  assign kind_unused = kind_i;
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ready;

  always_comb begin
    in_pix.red   = pixel_red_i;
    in_pix.green = pixel_green_i;
    in_pix.blue  = pixel_blue_i;
  end

  rsh_ctrl #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .ready_i     (ready),
    .take_o      (take),
    .tag_o       (tag),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr)
  );

  // One line buffer bank per row in rotation
  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    rsh_line_ram #(
      .Depth (MAX_WIDTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (mem_ctl.wr_en && (mem_ctl.wr_bank == bank_t'(k))),
      .waddr_i (mem_addr),
      .wdata_i (in_pix),
      .re_i    (mem_ctl.rd_en),
      .raddr_i (mem_addr),
      .rdata_o (bank_rd[k])
    );
  end

  rsh_filter u_filter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .tag_i        (tag),
    .pix_i        (in_pix),
    .bank_rd_i    (bank_rd),
    .ready_o      (ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_pix_o    (out_pix),
    .frame_last_o (frame_last_o)
  );

  assign out_red_o   = out_pix.red;
  assign out_green_o = out_pix.green;
  assign out_blue_o  = out_pix.blue;

endmodule

`default_nettype wire
